[hw/rtl/hre_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hre_pkg: shared types and constants
// Widths, datapath command/status structs for the reprojection error core.
// ----------------------------------------------------------------------------
package hre_pkg;
    localparam int COEF_WIDTH  = 21;
    localparam int COORD_WIDTH = 16;
    localparam int CFG_WIDTH   = 63;
    localparam int CFG_IDX_W   = 2;
    localparam int ERR_W       = 24;
    localparam int SUM_W       = 32;
    localparam int LIN_W       = 48;  // |coef*coord| sums fit in 48 bits signed
    localparam int NUM_W       = 64;  // |N| << 15
    localparam int QUO_W       = 31;  // clamp at 2^30
    localparam int SQ_W        = 64;  // dx^2 + dy^2
    localparam int RT_W        = 32;

    localparam logic [1:0] REG_ROW0 = 2'd0;
    localparam logic [1:0] REG_ROW1 = 2'd1;
    localparam logic [1:0] REG_ROW2 = 2'd2;

    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic load;       // capture input beat
        logic lin_step;   // advance multiply-accumulate sequencer
        logic div_start;  // start a division (sel picks numerator)
        logic div_sel;    // 0: x numerator, 1: y numerator
        logic sq_start;   // form dx^2 + dy^2, start root
        logic finish;     // capture result, update sum
    } hre_cmd_t;

    typedef struct packed {
        logic lin_done;
        logic degen;
        logic div_done;
        logic sqrt_done;
    } hre_sts_t;
endpackage

[hw/rtl/hre_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hre_ctrl: sequencer
// Steps a beat: linear forms, then two divisions and root unless degenerate.
// ----------------------------------------------------------------------------
module hre_ctrl import hre_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output hre_cmd_t cmd,
    input  hre_sts_t sts
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LIN  = 3'd1;
    localparam logic [2:0] ST_DIVX = 3'd2;
    localparam logic [2:0] ST_DIVY = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;

    // new beat may enter while a result waits; the finish step then waits
    // until the result slot frees
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg;
        cmd        = '0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LIN;
                end
            end
            ST_LIN: begin
                cmd.lin_step = 1'b1;
                if (sts.lin_done) begin
                    if (sts.degen) begin
                        state_next = ST_FIN;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVX;
                    end
                end
            end
            ST_DIVX: begin
                if (sts.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = 1'b1;
                    state_next    = ST_DIVY;
                end
            end
            ST_DIVY: begin
                if (sts.div_done) begin
                    cmd.sq_start = 1'b1;
                    state_next   = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sts.sqrt_done) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!mv_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end
endmodule

[hw/rtl/hre_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hre_datapath: arithmetic
// Shared multiplier for the linear forms, radix-2 divider, bitwise root,
// saturating accumulator and result registers.
// ----------------------------------------------------------------------------
module hre_datapath import hre_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_idx,
    input  logic [CFG_WIDTH-1:0]          cfg_data,
    input  logic signed [COORD_WIDTH-1:0] s_src_x,
    input  logic signed [COORD_WIDTH-1:0] s_src_y,
    input  logic signed [COORD_WIDTH-1:0] s_ref_x,
    input  logic signed [COORD_WIDTH-1:0] s_ref_y,
    input  logic                          s_last,
    input  hre_cmd_t                      cmd,
    output hre_sts_t                      sts,
    output logic [ERR_W-1:0]              m_point_error,
    output logic [SUM_W-1:0]              m_error_sum,
    output logic                          m_degenerate,
    output logic                          m_sum_final
);
    logic [CFG_WIDTH-1:0] row_reg [3];
    logic signed [COORD_WIDTH-1:0] sx_reg, sy_reg, rx_reg, ry_reg;
    logic last_reg;

    // linear forms: 9 products, one per cycle, walked by row and term counters
    logic [1:0] row_cnt_reg;
    logic [1:0] k_cnt_reg;
    logic       lin_done_reg;
    logic signed [LIN_W-1:0] acc_reg [3];
    logic signed [COEF_WIDTH-1:0] c_sel;
    logic signed [COORD_WIDTH+1:0] v_sel;   // x, y or 16
    logic signed [COEF_WIDTH+COORD_WIDTH+1:0] prod;

    always_comb begin
        c_sel = row_reg[row_cnt_reg][k_cnt_reg*COEF_WIDTH +: COEF_WIDTH];
        case (k_cnt_reg)
            2'd0:    v_sel = (COORD_WIDTH+2)'(sx_reg);
            2'd1:    v_sel = (COORD_WIDTH+2)'(sy_reg);
            default: v_sel = (COORD_WIDTH+2)'(16);
        endcase
        prod = c_sel * v_sel;
    end

    assign sts.lin_done = lin_done_reg;
    assign sts.degen    = (acc_reg[2] == '0);

    // divider: q = (|N|<<15 + |D|/2) / |D|, restoring, 1 bit per cycle
    logic [NUM_W-1:0] dvd_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [LIN_W-1:0] dsr_reg;
    logic [6:0]       div_cnt_reg;
    logic             div_busy_reg, div_neg_reg;
    logic signed [QUO_W:0] u_reg, v_reg;
    logic             div_dst_reg;
    logic [LIN_W-1:0] an, ad;
    logic signed [LIN_W-1:0] nsel;
    logic [NUM_W:0]   rem_sh;
    logic [NUM_W-1:0] qv;
    logic [QUO_W-1:0] qc;

    always_comb begin
        nsel   = cmd.div_sel ? acc_reg[1] : acc_reg[0];
        an     = nsel[LIN_W-1] ? LIN_W'(-nsel) : LIN_W'(nsel);
        ad     = acc_reg[2][LIN_W-1] ? LIN_W'(-acc_reg[2]) : LIN_W'(acc_reg[2]);
        rem_sh = {rem_reg, dvd_reg[NUM_W-1]};
        qv     = dvd_reg;
        qc     = (qv > NUM_W'(64'd1 << 30)) ? QUO_W'(31'd1 << 30) : QUO_W'(qv);
    end
    // done once the rounded, signed quotient sits in u_reg or v_reg
    assign sts.div_done = !div_busy_reg && (div_cnt_reg == 7'd66);

    // root of dx^2+dy^2, two bits per step
    logic [SQ_W-1:0] sv_reg, sr_reg, sb_reg;
    logic            sq_busy_reg;
    logic signed [QUO_W+1:0] dx, dy;
    logic signed [2*QUO_W+3:0] dx2, dy2;
    logic [SQ_W-1:0] s_sum;
    logic [SQ_W-1:0] rb;
    assign dx    = (QUO_W+2)'(rx_reg) - (QUO_W+2)'(u_reg);
    assign dy    = (QUO_W+2)'(ry_reg) - (QUO_W+2)'(v_reg);
    assign dx2   = dx * dx;
    assign dy2   = dy * dy;
    assign s_sum = SQ_W'(dx2) + SQ_W'(dy2);
    assign rb    = sr_reg + sb_reg;
    assign sts.sqrt_done = !sq_busy_reg;

    logic [SQ_W-1:0] root_r;
    logic [ERR_W-1:0] err;
    logic [SUM_W:0]   sum_w;
    logic [SUM_W-1:0] sum_reg;
    always_comb begin
        root_r = (sv_reg > sr_reg) ? sr_reg + 1'b1 : sr_reg;
        if (sts.degen)              err = ERR_MAX;
        else if (root_r > SQ_W'(ERR_MAX)) err = ERR_MAX;
        else                        err = ERR_W'(root_r);
        sum_w = {1'b0, sum_reg} + (SUM_W+1)'(err);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0]   <= '0;
            row_reg[1]   <= '0;
            row_reg[2]   <= '0;
            sum_reg      <= '0;
            row_cnt_reg  <= '0;
            k_cnt_reg    <= '0;
            lin_done_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            sq_busy_reg  <= 1'b0;
        end else begin
            if (cfg_we && (cfg_idx == REG_ROW0 || cfg_idx == REG_ROW1 ||
                           cfg_idx == REG_ROW2))
                row_reg[cfg_idx] <= cfg_data;
            if (cmd.load) begin
                sx_reg <= s_src_x; sy_reg <= s_src_y;
                rx_reg <= s_ref_x; ry_reg <= s_ref_y;
                last_reg     <= s_last;
                row_cnt_reg  <= '0;
                k_cnt_reg    <= '0;
                lin_done_reg <= 1'b0;
                acc_reg[0] <= '0; acc_reg[1] <= '0; acc_reg[2] <= '0;
            end else if (cmd.lin_step && !lin_done_reg) begin
                acc_reg[row_cnt_reg] <= acc_reg[row_cnt_reg] + LIN_W'(prod);
                if (k_cnt_reg == 2'd2) begin
                    k_cnt_reg <= '0;
                    if (row_cnt_reg == 2'd2) lin_done_reg <= 1'b1;
                    else row_cnt_reg <= row_cnt_reg + 1'b1;
                end else begin
                    k_cnt_reg <= k_cnt_reg + 1'b1;
                end
            end
            // divider: step count 64, dividend register shifts in quotient
            if (cmd.div_start) begin
                dvd_reg      <= NUM_W'(an) << 15;
                rem_reg      <= '0;
                dsr_reg      <= ad;
                div_cnt_reg  <= '0;
                div_busy_reg <= 1'b1;
                div_neg_reg  <= nsel[LIN_W-1] ^ acc_reg[2][LIN_W-1];
                div_dst_reg  <= cmd.div_sel;
            end else if (div_busy_reg) begin
                if (rem_sh >= (NUM_W+1)'(dsr_reg)) begin
                    rem_reg <= NUM_W'(rem_sh - (NUM_W+1)'(dsr_reg));
                    dvd_reg <= {dvd_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= NUM_W'(rem_sh);
                    dvd_reg <= {dvd_reg[NUM_W-2:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == 7'd63) div_busy_reg <= 1'b0;
            end else if (div_cnt_reg == 7'd64) begin
                // round: compare 2*rem with divisor (same as adding |D|/2 first)
                div_cnt_reg <= 7'd65;
            end
            if (div_cnt_reg == 7'd64 && !div_busy_reg && !cmd.div_start) begin
                if ({rem_reg, 1'b0} >= {1'b0, NUM_W'(dsr_reg)} + (NUM_W+1)'(dsr_reg[0]))
                    dvd_reg <= dvd_reg + 1'b1;
            end
            if (div_cnt_reg == 7'd65) begin
                if (div_dst_reg) v_reg <= div_neg_reg ? -(QUO_W+1)'(qc) : (QUO_W+1)'(qc);
                else             u_reg <= div_neg_reg ? -(QUO_W+1)'(qc) : (QUO_W+1)'(qc);
                div_cnt_reg <= 7'd66;
            end
            if (cmd.sq_start) begin
                sv_reg      <= s_sum;
                sr_reg      <= '0;
                sb_reg      <= SQ_W'(64'd1 << 62);
                sq_busy_reg <= 1'b1;
            end else if (sq_busy_reg) begin
                if (sb_reg == '0) begin
                    sq_busy_reg <= 1'b0;
                end else begin
                    if (sv_reg >= rb) begin
                        sv_reg <= sv_reg - rb;
                        sr_reg <= (sr_reg >> 1) + sb_reg;
                    end else begin
                        sr_reg <= sr_reg >> 1;
                    end
                    sb_reg <= sb_reg >> 2;
                end
            end
            if (cmd.finish) begin
                if (last_reg) sum_reg <= '0;
                else sum_reg <= sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_point_error <= err;
            m_error_sum   <= sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
            m_degenerate  <= sts.degen;
            m_sum_final   <= last_reg;
        end
    end
endmodule

[hw/rtl/homography_reprojection_error_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography_reprojection_error_core: homography reprojection error sum
//   channel | ports                                   | dir
//   input   | s_valid/s_ready, s_src_*, s_ref_*, s_last | in
//   result  | m_valid/m_ready, m_point_error, ...     | out
//   config  | cfg_we, cfg_idx, cfg_data               | in
// Per beat: accept, nine products for the linear forms, two divisions,
// the root and finish; a zero denominator skips from the linear forms to
// finish. The serial divider sets the rate, and no new beat is taken until
// the last leaves finish. Synchronous active-low reset clears state and the
// running sum. A stalled result holds the next beat in finish.
// ----------------------------------------------------------------------------
module homography_reprojection_error_core import hre_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_idx,
    input  logic [CFG_WIDTH-1:0]          cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_src_x,
    input  logic signed [COORD_WIDTH-1:0] s_src_y,
    input  logic signed [COORD_WIDTH-1:0] s_ref_x,
    input  logic signed [COORD_WIDTH-1:0] s_ref_y,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ERR_W-1:0]              m_point_error,
    output logic [SUM_W-1:0]              m_error_sum,
    output logic                          m_degenerate,
    output logic                          m_sum_final
);
    hre_cmd_t cmd;
    hre_sts_t sts;

    hre_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    hre_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .s_src_x(s_src_x), .s_src_y(s_src_y),
        .s_ref_x(s_ref_x), .s_ref_y(s_ref_y), .s_last(s_last), .cmd(cmd),
        .sts(sts), .m_point_error(m_point_error), .m_error_sum(m_error_sum),
        .m_degenerate(m_degenerate), .m_sum_final(m_sum_final)
    );

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_error_sum))
        else $error("result dropped while stalled");
    a_degen_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_degenerate |-> m_point_error == ERR_MAX)
        else $error("degenerate point not saturated");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while busy");
endmodule
